// ===== rtl/swdg_pkg.sv =====
// ----------------------------------------------------------------------------
// swdg_pkg
// Shared constants and the sine table builder for the DDS sine generator.
// ----------------------------------------------------------------------------
package swdg_pkg;

  // Default parameter values
  localparam int DEF_PHASE_BITS      = 32;
  localparam int DEF_SINE_TABLE_BITS = 10;
  localparam int DEF_DAC_BITS        = 12;
  localparam int DEF_FULL_SCALE_MV   = 3300;

  // Register file layout
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MV_W      = 11;
  localparam int PHASE_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd3;

  localparam logic [MV_W-1:0]    RST_AMPLITUDE = 11'd1000;
  localparam logic [MV_W-1:0]    RST_MEAN      = 11'd1000;
  localparam logic [PHASE_W-1:0] RST_STEP      = 32'd42949673;
  localparam logic [PHASE_W-1:0] RST_OFFSET    = 32'd0;

  // Q0.15 sine magnitude
  localparam int SAMPLE_W = 15;

  // pi/2 in Q30 and the Taylor series divisors (2n)(2n+1)
  localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  // One quarter-wave table entry: sin(pi/2 * k / 2^table_bits) in Q0.15
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int k, input int table_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          q;
    x    = (PIHALF_Q30 * longint'(k)) >> table_bits;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      q = 0;
    end else begin
      q = (acc + 16384) >>> 15;
    end
    if (q > 32767) begin
      q = 32767;
    end
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== rtl/sine_wave_dac_generator_unit.sv =====
// ----------------------------------------------------------------------------
// sine_wave_dac_generator_unit
// DDS sine generator: phase accumulator, quarter-wave table, amplitude and
// mean in millivolts, saturation and conversion to a DAC code.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+-----------
//  in      | in_valid, in_stall, tick         | item in
//  out     | out_valid, out_stall, dac_code,  | item out
//          | clipped                          |
//  cfg     | cfg_we, cfg_index, cfg_data      | write only
//
//  An item is taken from idle when in_valid and tick are both high; its
//  result is ready in the done state. The sequencer runs the one shared
//  multiplier four times per sample (amplitude, DAC scale, reciprocal,
//  back-multiply) and the one phase adder twice.
//  Reset clears the accumulator, loads register defaults and idles.
//  A stalled result waits in the output register; the next item is not
//  taken until the finished one has moved into it.
// ----------------------------------------------------------------------------
module sine_wave_dac_generator_unit
  import swdg_pkg::*;
#(
  parameter int PHASE_BITS      = DEF_PHASE_BITS,
  parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
  parameter int DAC_BITS        = DEF_DAC_BITS,
  parameter int FULL_SCALE_MV   = DEF_FULL_SCALE_MV
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 tick,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DAC_BITS-1:0]  dac_code,
  output logic                 clipped,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int  TB          = SINE_TABLE_BITS;
  localparam int  QUARTER_LEN = 1 << TB;
  localparam int  HALF_MV     = FULL_SCALE_MV / 2;
  localparam int  FS_W        = $clog2(FULL_SCALE_MV + 1);
  localparam longint DAC_MAX  = (longint'(1) << DAC_BITS) - 1;
  localparam int  MUL_W       = $clog2(longint'(FULL_SCALE_MV) * DAC_MAX + 1);
  localparam longint RECIP    = (longint'(1) << MUL_W) / FULL_SCALE_MV;
  localparam int  AMP_PROD_W  = MV_W + SAMPLE_W;
  localparam int  VOLT_W      = 14;

  localparam logic [TB:0] QUARTER_IDX = {1'b1, {TB{1'b0}}};

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PHASE    = 4'd1;
  localparam logic [3:0] S_ADV      = 4'd2;
  localparam logic [3:0] S_MUL_AMP  = 4'd3;
  localparam logic [3:0] S_VOLT     = 4'd4;
  localparam logic [3:0] S_MUL_DAC  = 4'd5;
  localparam logic [3:0] S_MUL_REC  = 4'd6;
  localparam logic [3:0] S_MUL_BACK = 4'd7;
  localparam logic [3:0] S_FIX      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  // Configuration registers
  logic [MV_W-1:0]    amplitude_mv;
  logic [MV_W-1:0]    mean_mv;
  logic [PHASE_W-1:0] phase_step;
  logic [PHASE_W-1:0] phase_offset;
  logic [MV_W-1:0]    cfg_capped;

  // Sequencer and datapath registers
  logic [3:0]            state;
  logic [3:0]            state_next;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [TB:0]           rom_addr;
  logic                  neg;
  logic [SAMPLE_W-1:0]   mag;
  logic [2*MUL_W-1:0]    mul_p;
  logic [FS_W-1:0]       volt;
  logic                  clip;
  logic [MUL_W-1:0]      num;
  logic [DAC_BITS-1:0]   q_est;
  logic [DAC_BITS-1:0]   code;

  // Combinational
  logic [PHASE_BITS-1:0] step_al;
  logic [PHASE_BITS-1:0] offset_al;
  logic [PHASE_BITS-1:0] add_b;
  logic [PHASE_BITS-1:0] add_sum;
  logic [1:0]            quad;
  logic [TB-1:0]         k_idx;
  logic [TB:0]           rom_addr_next;
  logic [SAMPLE_W-1:0]   sine_rom [QUARTER_LEN+1];
  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;
  logic                  mul_en;
  logic [AMP_PROD_W:0]   round_sum;
  logic [MV_W:0]         r_mv;
  logic signed [VOLT_W-1:0] v_mv;
  logic [MUL_W-1:0]      rem;
  logic                  out_free;

  // ---------------- configuration ----------------
  assign cfg_capped = ({2'b00, cfg_data[MV_W-1:0]} > 13'(HALF_MV)) ?
                      MV_W'(HALF_MV) : cfg_data[MV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude_mv <= RST_AMPLITUDE;
      mean_mv      <= RST_MEAN;
      phase_step   <= RST_STEP;
      phase_offset <= RST_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AMPLITUDE: amplitude_mv <= cfg_capped;
        REG_MEAN:      mean_mv      <= cfg_capped;
        REG_STEP:      phase_step   <= cfg_data[PHASE_W-1:0];
        REG_OFFSET:    phase_offset <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- phase alignment ----------------
  generate
    if (PHASE_BITS > PHASE_W) begin : g_wide
      assign step_al   = {phase_step,   {(PHASE_BITS-PHASE_W){1'b0}}};
      assign offset_al = {phase_offset, {(PHASE_BITS-PHASE_W){1'b0}}};
    end else if (PHASE_BITS == PHASE_W) begin : g_same
      assign step_al   = phase_step;
      assign offset_al = phase_offset;
    end else begin : g_narrow
      assign step_al   = phase_step[PHASE_W-1 -: PHASE_BITS];
      assign offset_al = phase_offset[PHASE_W-1 -: PHASE_BITS];
    end
  endgenerate

  // ---------------- quarter-wave table ----------------
  generate
    for (genvar g = 0; g <= QUARTER_LEN; g++) begin : g_rom
      localparam logic [SAMPLE_W-1:0] ENTRY = sine_entry(g, TB);
      assign sine_rom[g] = ENTRY;
    end
  endgenerate

  // Shared phase adder: offset first, then the step
  assign add_b   = (state == S_ADV) ? step_al : offset_al;
  assign add_sum = phase_acc + add_b;
  assign quad    = add_sum[PHASE_BITS-1 -: 2];
  assign k_idx   = add_sum[PHASE_BITS-3 -: TB];
  assign rom_addr_next = quad[0] ? (QUARTER_IDX - {1'b0, k_idx}) : {1'b0, k_idx};

  // ---------------- shared multiplier ----------------
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state)
      S_MUL_AMP: begin
        mul_a = MUL_W'(amplitude_mv);
        mul_b = MUL_W'(mag);
      end
      S_MUL_DAC: begin
        mul_a = MUL_W'(volt);
        mul_b = MUL_W'(DAC_MAX);
      end
      S_MUL_REC: begin
        mul_a = mul_p[MUL_W-1:0];
        mul_b = MUL_W'(RECIP);
      end
      S_MUL_BACK: begin
        mul_a = MUL_W'(mul_p[MUL_W +: DAC_BITS]);
        mul_b = MUL_W'(FULL_SCALE_MV);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_p <= {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
    end
  end

  // Round half away from zero on the magnitude, then apply the sign
  assign round_sum = {1'b0, mul_p[AMP_PROD_W-1:0]} + (AMP_PROD_W+1)'(16384);
  assign r_mv      = round_sum[AMP_PROD_W:SAMPLE_W];
  assign v_mv      = neg ? ($signed({3'b000, mean_mv}) - $signed({2'b00, r_mv}))
                         : ($signed({3'b000, mean_mv}) + $signed({2'b00, r_mv}));

  // Reciprocal quotient is low by at most one
  assign rem = num - mul_p[MUL_W-1:0];

  assign out_free = !out_valid || !out_stall;

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid && tick) state_next = S_PHASE;
      S_PHASE:    state_next = S_ADV;
      S_ADV:      state_next = S_MUL_AMP;
      S_MUL_AMP:  state_next = S_VOLT;
      S_VOLT:     state_next = S_MUL_DAC;
      S_MUL_DAC:  state_next = S_MUL_REC;
      S_MUL_REC:  state_next = S_MUL_BACK;
      S_MUL_BACK: state_next = S_FIX;
      S_FIX:      state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase_acc <= '0;
    end else begin
      state <= state_next;
      if (state == S_ADV) begin
        phase_acc <= add_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_PHASE: begin
        rom_addr <= rom_addr_next;
        neg      <= quad[1];
      end
      S_ADV: mag <= sine_rom[rom_addr];
      S_VOLT: begin
        // saturate to the rail and flag it
        if (v_mv < 0) begin
          volt <= '0;
          clip <= 1'b1;
        end else if (v_mv > $signed(VOLT_W'(FULL_SCALE_MV))) begin
          volt <= FS_W'(FULL_SCALE_MV);
          clip <= 1'b1;
        end else begin
          volt <= v_mv[FS_W-1:0];
          clip <= 1'b0;
        end
      end
      S_MUL_REC:  num   <= mul_p[MUL_W-1:0];
      S_MUL_BACK: q_est <= mul_p[MUL_W +: DAC_BITS];
      S_FIX:      code  <= q_est + DAC_BITS'(rem >= MUL_W'(FULL_SCALE_MV));
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      dac_code <= code;
      clipped  <= clip;
    end
  end

  // ---------------- assertions ----------------
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (dac_code == '0 || dac_code == DAC_BITS'(DAC_MAX)))
    else $error("clipped item not at a rail");

  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && state != S_ADV) |=> $stable(phase_acc))
    else $error("phase accumulator moved outside its advance step");

  a_recip_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |-> (rem < MUL_W'(2 * FULL_SCALE_MV)))
    else $error("reciprocal quotient off by more than one");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result appeared without a finished item");

endmodule
